>>> rtl/kbs_pkg.sv
// Shared types and codes of the keyed bucket sorter.
`default_nettype none
package kbs_pkg;

   localparam int MODE_BITS   = 2;
   localparam int STATUS_BITS = 2;
   localparam int CMD_BITS    = 4;

   localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_READ   = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_END  = 2'd2;

   localparam logic [CMD_BITS-1:0] C_NOP       = 4'd0;
   localparam logic [CMD_BITS-1:0] C_LOAD      = 4'd1;
   localparam logic [CMD_BITS-1:0] C_INS_WR    = 4'd2;
   localparam logic [CMD_BITS-1:0] C_INS_LINK  = 4'd3;
   localparam logic [CMD_BITS-1:0] C_REM_START = 4'd4;
   localparam logic [CMD_BITS-1:0] C_REM_WALK  = 4'd5;
   localparam logic [CMD_BITS-1:0] C_REM_FIN   = 4'd6;
   localparam logic [CMD_BITS-1:0] C_RD_SCAN   = 4'd7;
   localparam logic [CMD_BITS-1:0] C_RD_FIRST  = 4'd8;
   localparam logic [CMD_BITS-1:0] C_RD_NODE   = 4'd9;
   localparam logic [CMD_BITS-1:0] C_POST      = 4'd10;

   typedef struct packed {
      logic [CMD_BITS-1:0] code;
   } cmd_type;

   typedef struct packed {
      logic used_k;
      logic full;
      logic append;
      logic walk_end;
      logic read_direct;
      logic scan_end;
      logic scan_hit;
      logic first_none;
      logic rsp_busy;
   } stat_type;

endpackage
`default_nettype wire

>>> rtl/kbs_if.sv
// Request and response channel interfaces of the keyed bucket sorter.
`default_nettype none
interface kbs_req_if #(
   parameter int KEY_BITS   = 8,
   parameter int VALUE_BITS = 32
);
   logic                           valid;
   logic                           ready;
   logic [kbs_pkg::MODE_BITS-1:0]  mode;
   logic [KEY_BITS-1:0]            key;
   logic [VALUE_BITS-1:0]          item_value;

   modport source (output valid, mode, key, item_value, input ready);
   modport sink   (input valid, mode, key, item_value, output ready);
endinterface

interface kbs_rsp_if #(
   parameter int KEY_BITS   = 8,
   parameter int VALUE_BITS = 32,
   parameter int COUNT_BITS = 11
);
   logic                            valid;
   logic                            ready;
   logic [kbs_pkg::STATUS_BITS-1:0] status;
   logic [KEY_BITS-1:0]             out_key;
   logic [VALUE_BITS-1:0]           out_value;
   logic [COUNT_BITS-1:0]           removed_count;

   modport source (output valid, status, out_key, out_value, removed_count, input ready);
   modport sink   (input valid, status, out_key, out_value, removed_count, output ready);
endinterface
`default_nettype wire

>>> rtl/kbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

>>> rtl/kbs_ctrl.sv
// Controller state machine of the keyed bucket sorter.
`default_nettype none
module kbs_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic [kbs_pkg::MODE_BITS-1:0] req_mode,
   input  wire kbs_pkg::stat_type             stat,
   output logic                               req_ready,
   output kbs_pkg::cmd_type                   cmd
);
   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_INS_WR    = 4'd1;
   localparam logic [3:0] S_INS_LINK  = 4'd2;
   localparam logic [3:0] S_REM_START = 4'd3;
   localparam logic [3:0] S_REM_WALK  = 4'd4;
   localparam logic [3:0] S_REM_FIN   = 4'd5;
   localparam logic [3:0] S_RD_SCAN   = 4'd6;
   localparam logic [3:0] S_RD_FIRST  = 4'd7;
   localparam logic [3:0] S_RD_NODE   = 4'd8;
   localparam logic [3:0] S_POST      = 4'd9;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.code = kbs_pkg::C_NOP;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.code = kbs_pkg::C_LOAD;
               case (req_mode)
                  kbs_pkg::MODE_INSERT: state_in = S_INS_WR;
                  kbs_pkg::MODE_REMOVE: state_in = S_REM_START;
                  kbs_pkg::MODE_READ:   state_in = stat.read_direct ? S_RD_NODE : S_RD_SCAN;
                  default:              state_in = S_POST;
               endcase
            end
         end
         S_INS_WR: begin
            cmd.code = kbs_pkg::C_INS_WR;
            state_in = (!stat.full && stat.append) ? S_INS_LINK : S_POST;
         end
         S_INS_LINK: begin
            cmd.code = kbs_pkg::C_INS_LINK;
            state_in = S_POST;
         end
         S_REM_START: begin
            cmd.code = kbs_pkg::C_REM_START;
            state_in = stat.used_k ? S_REM_WALK : S_POST;
         end
         S_REM_WALK: begin
            cmd.code = kbs_pkg::C_REM_WALK;
            if (stat.walk_end) begin
               state_in = S_REM_FIN;
            end
         end
         S_REM_FIN: begin
            cmd.code = kbs_pkg::C_REM_FIN;
            state_in = S_POST;
         end
         S_RD_SCAN: begin
            cmd.code = kbs_pkg::C_RD_SCAN;
            if (stat.scan_end) begin
               state_in = S_POST;
            end else if (stat.scan_hit) begin
               state_in = S_RD_FIRST;
            end
         end
         S_RD_FIRST: begin
            cmd.code = kbs_pkg::C_RD_FIRST;
            state_in = stat.first_none ? S_POST : S_RD_NODE;
         end
         S_RD_NODE: begin
            cmd.code = kbs_pkg::C_RD_NODE;
            state_in = S_POST;
         end
         S_POST: begin
            if (!stat.rsp_busy) begin
               cmd.code = kbs_pkg::C_POST;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   ap_walk_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REM_WALK && stat.walk_end) |=> (state_ff == S_REM_FIN))
      else $error("walk end did not finish remove");
   ap_post_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POST && !stat.rsp_busy) |=> (state_ff == S_IDLE))
      else $error("post did not return to idle");
   ap_load_leave: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> (state_ff != S_IDLE))
      else $error("accepted word left controller idle");
endmodule
`default_nettype wire

>>> rtl/kbs_datapath.sv
// Datapath of the keyed bucket sorter: node and bucket memories, pointers, result.
`default_nettype none
module kbs_datapath #(
   parameter int KEY_BITS   = 8,
   parameter int VALUE_BITS = 32,
   parameter int POOL_DEPTH = 1024,
   parameter int NODE_BITS  = $clog2(POOL_DEPTH + 1)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire kbs_pkg::cmd_type                cmd,
   output kbs_pkg::stat_type                    stat,
   input  wire logic [kbs_pkg::MODE_BITS-1:0]   req_mode,
   input  wire logic [KEY_BITS-1:0]             req_key,
   input  wire logic [VALUE_BITS-1:0]           req_value,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_valid,
   output logic [kbs_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [KEY_BITS-1:0]                  rsp_key,
   output logic [VALUE_BITS-1:0]                rsp_value,
   output logic [NODE_BITS-1:0]                 rsp_count
);
   localparam int KEY_COUNT = 2 ** KEY_BITS;
   localparam int ADDR_BITS = $clog2(POOL_DEPTH);
   localparam logic [NODE_BITS-1:0] NONE = NODE_BITS'(POOL_DEPTH);

   logic                  nd_we;
   logic [ADDR_BITS-1:0]  nd_waddr, nd_raddr;
   logic [VALUE_BITS-1:0] nd_rdata;
   logic                  nl_we;
   logic [ADDR_BITS-1:0]  nl_waddr, nl_raddr;
   logic [NODE_BITS-1:0]  nl_wdata, nl_rdata;
   logic                  bf_we;
   logic [KEY_BITS-1:0]   bf_raddr;
   logic [NODE_BITS-1:0]  bf_wdata, bf_rdata;
   logic                  bl_we;
   logic [NODE_BITS-1:0]  bl_wdata, bl_rdata;

   logic [KEY_BITS-1:0]              op_key_ff, op_key_in;
   logic [VALUE_BITS-1:0]            op_value_ff, op_value_in;
   logic [KEY_COUNT-1:0]             used_ff, used_in;
   logic [NODE_BITS-1:0]             fresh_ff, fresh_in;
   logic [NODE_BITS-1:0]             free_top_ff, free_top_in;
   logic [KEY_BITS:0]                read_key_ff, read_key_in;
   logic [NODE_BITS-1:0]             read_node_ff, read_node_in;
   logic [KEY_BITS:0]                scan_ff, scan_in;
   logic [NODE_BITS-1:0]             cur_ff, cur_in;
   logic [NODE_BITS-1:0]             prev_ff, prev_in;
   logic [NODE_BITS-1:0]             count_ff, count_in;
   logic [NODE_BITS-1:0]             node_ff, node_in;
   logic [NODE_BITS-1:0]             last_ff, last_in;
   logic [kbs_pkg::STATUS_BITS-1:0]  res_status_ff, res_status_in;
   logic [KEY_BITS-1:0]              res_key_ff, res_key_in;
   logic [VALUE_BITS-1:0]            res_value_ff, res_value_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [kbs_pkg::STATUS_BITS-1:0]  rsp_status_ff, rsp_status_in;
   logic [KEY_BITS-1:0]              rsp_key_ff, rsp_key_in;
   logic [VALUE_BITS-1:0]            rsp_value_ff, rsp_value_in;
   logic [NODE_BITS-1:0]             rsp_count_ff, rsp_count_in;

   logic                 use_free;
   logic [NODE_BITS-1:0] new_node;

   kbs_ram #(.WIDTH(VALUE_BITS), .DEPTH(POOL_DEPTH)) u_node_data (
      .clock(clock), .wr_en(nd_we), .wr_addr(nd_waddr), .wr_data(op_value_ff),
      .rd_addr(nd_raddr), .rd_data(nd_rdata));
   kbs_ram #(.WIDTH(NODE_BITS), .DEPTH(POOL_DEPTH)) u_node_link (
      .clock(clock), .wr_en(nl_we), .wr_addr(nl_waddr), .wr_data(nl_wdata),
      .rd_addr(nl_raddr), .rd_data(nl_rdata));
   kbs_ram #(.WIDTH(NODE_BITS), .DEPTH(KEY_COUNT)) u_bucket_first (
      .clock(clock), .wr_en(bf_we), .wr_addr(op_key_ff), .wr_data(bf_wdata),
      .rd_addr(bf_raddr), .rd_data(bf_rdata));
   kbs_ram #(.WIDTH(NODE_BITS), .DEPTH(KEY_COUNT)) u_bucket_last (
      .clock(clock), .wr_en(bl_we), .wr_addr(op_key_ff), .wr_data(bl_wdata),
      .rd_addr(req_key), .rd_data(bl_rdata));

   assign use_free = (free_top_ff < NONE);
   assign new_node = use_free ? free_top_ff : fresh_ff;

   always_comb begin
      stat.used_k      = used_ff[op_key_ff];
      stat.full        = !use_free && (fresh_ff >= NONE);
      stat.append      = used_ff[op_key_ff] && (bl_rdata < NONE);
      stat.walk_end    = (nl_rdata >= NONE);
      stat.read_direct = (read_node_ff < NONE);
      stat.scan_end    = scan_ff[KEY_BITS];
      stat.scan_hit    = used_ff[scan_ff[KEY_BITS-1:0]];
      stat.first_none  = (bf_rdata >= NONE);
      stat.rsp_busy    = rsp_valid_ff && !rsp_ready;
   end

   always_comb begin
      nd_we    = 1'b0;
      nd_waddr = new_node[ADDR_BITS-1:0];
      nd_raddr = read_node_ff[ADDR_BITS-1:0];
      nl_we    = 1'b0;
      nl_waddr = new_node[ADDR_BITS-1:0];
      nl_wdata = NONE;
      nl_raddr = read_node_ff[ADDR_BITS-1:0];
      bf_we    = 1'b0;
      bf_wdata = new_node;
      bf_raddr = req_key;
      bl_we    = 1'b0;
      bl_wdata = new_node;

      op_key_in     = op_key_ff;
      op_value_in   = op_value_ff;
      used_in       = used_ff;
      fresh_in      = fresh_ff;
      free_top_in   = free_top_ff;
      read_key_in   = read_key_ff;
      read_node_in  = read_node_ff;
      scan_in       = scan_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      count_in      = count_ff;
      node_in       = node_ff;
      last_in       = last_ff;
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;

      case (cmd.code)
         kbs_pkg::C_LOAD: begin
            if (req_mode == kbs_pkg::MODE_INSERT) begin
               nl_raddr = free_top_ff[ADDR_BITS-1:0];
            end
            op_key_in     = req_key;
            op_value_in   = req_value;
            scan_in       = read_key_ff;
            count_in      = '0;
            res_status_in = kbs_pkg::ST_OK;
            res_key_in    = '0;
            res_value_in  = '0;
         end
         kbs_pkg::C_INS_WR: begin
            if (stat.full) begin
               res_status_in = kbs_pkg::ST_FULL;
            end else begin
               if (use_free) begin
                  free_top_in = nl_rdata;
               end else begin
                  fresh_in = fresh_ff + 1'b1;
               end
               nd_we = 1'b1;
               nl_we = 1'b1;
               bl_we = 1'b1;
               node_in = new_node;
               last_in = bl_rdata;
               if (!stat.append) begin
                  bf_we = 1'b1;
                  used_in[op_key_ff] = 1'b1;
               end
            end
         end
         kbs_pkg::C_INS_LINK: begin
            nl_we    = 1'b1;
            nl_waddr = last_ff[ADDR_BITS-1:0];
            nl_wdata = node_ff;
         end
         kbs_pkg::C_REM_START: begin
            read_key_in  = '0;
            read_node_in = NONE;
            nd_raddr     = bf_rdata[ADDR_BITS-1:0];
            nl_raddr     = bf_rdata[ADDR_BITS-1:0];
            cur_in       = bf_rdata;
            prev_in      = NONE;
         end
         kbs_pkg::C_REM_WALK: begin
            nd_raddr = nl_rdata[ADDR_BITS-1:0];
            nl_raddr = nl_rdata[ADDR_BITS-1:0];
            cur_in   = nl_rdata;
            if (nd_rdata == op_value_ff) begin
               nl_we       = 1'b1;
               nl_waddr    = cur_ff[ADDR_BITS-1:0];
               nl_wdata    = free_top_ff;
               free_top_in = cur_ff;
               count_in    = count_ff + 1'b1;
            end else begin
               if (prev_ff >= NONE) begin
                  bf_we    = 1'b1;
                  bf_wdata = cur_ff;
               end else begin
                  nl_we    = 1'b1;
                  nl_waddr = prev_ff[ADDR_BITS-1:0];
                  nl_wdata = cur_ff;
               end
               prev_in = cur_ff;
            end
         end
         kbs_pkg::C_REM_FIN: begin
            if (prev_ff >= NONE) begin
               used_in[op_key_ff] = 1'b0;
            end else begin
               nl_we    = 1'b1;
               nl_waddr = prev_ff[ADDR_BITS-1:0];
               nl_wdata = NONE;
               bl_we    = 1'b1;
               bl_wdata = prev_ff;
            end
         end
         kbs_pkg::C_RD_SCAN: begin
            bf_raddr = scan_ff[KEY_BITS-1:0];
            if (stat.scan_end) begin
               res_status_in = kbs_pkg::ST_END;
               read_key_in   = '0;
               read_node_in  = NONE;
            end else if (!stat.scan_hit) begin
               scan_in = scan_ff + 1'b1;
            end
         end
         kbs_pkg::C_RD_FIRST: begin
            nd_raddr = bf_rdata[ADDR_BITS-1:0];
            nl_raddr = bf_rdata[ADDR_BITS-1:0];
            if (stat.first_none) begin
               res_status_in = kbs_pkg::ST_END;
               read_key_in   = '0;
               read_node_in  = NONE;
            end
         end
         kbs_pkg::C_RD_NODE: begin
            res_key_in   = scan_ff[KEY_BITS-1:0];
            res_value_in = nd_rdata;
            if (nl_rdata >= NONE) begin
               read_key_in  = scan_ff + 1'b1;
               read_node_in = NONE;
            end else begin
               read_key_in  = scan_ff;
               read_node_in = nl_rdata;
            end
         end
         kbs_pkg::C_POST: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = res_status_ff;
            rsp_key_in    = res_key_ff;
            rsp_value_in  = res_value_ff;
            rsp_count_in  = count_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         fresh_ff     <= '0;
         free_top_ff  <= NONE;
         read_key_ff  <= '0;
         read_node_ff <= NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         fresh_ff     <= fresh_in;
         free_top_ff  <= free_top_in;
         read_key_ff  <= read_key_in;
         read_node_ff <= read_node_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_key_ff     <= op_key_in;
      op_value_ff   <= op_value_in;
      scan_ff       <= scan_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      count_ff      <= count_in;
      node_ff       <= node_in;
      last_ff       <= last_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_key    = rsp_key_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_count  = rsp_count_ff;

   ap_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= NONE)
      else $error("fresh node count beyond pool");
   ap_full_hold: assert property (@(posedge clock) disable iff (reset)
      (cmd.code == kbs_pkg::C_INS_WR && stat.full) |=> $stable(fresh_ff) && $stable(used_ff))
      else $error("dropped insert changed state");
   ap_post_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.code == kbs_pkg::C_POST) |=> rsp_valid_ff)
      else $error("posted word not presented");
   ap_remove_rewind: assert property (@(posedge clock) disable iff (reset)
      (cmd.code == kbs_pkg::C_REM_START) |=> (read_node_ff == NONE) && (read_key_ff == '0))
      else $error("remove did not rewind read cursor");
endmodule
`default_nettype wire

>>> rtl/keyed_bucket_sorter.sv
// Keyed bucket sorter top level: controller, datapath and channel ports.
//
// req_chan carries one word per operation: mode (insert, remove all matching,
// read next), key and item_value. rsp_chan returns exactly one word per request
// with status, out_key, out_value and removed_count; unused fields read zero.
// One request is worked on at a time; req_chan.ready is high while idle, so a
// new word is accepted only after the previous operation has been posted.
// Work from accept to the response word being valid:
//   insert: the node is written, then linked behind the old tail when it is
//           appended to a non-empty bucket; a full pool drops the insert.
//   remove: an empty bucket goes straight to the response, else the bucket
//           is walked; one node is walked per cycle through the node link memory.
//   read:   the node is read directly when the cursor sits inside a bucket,
//           else the bucket used flags are checked one key per cycle.
// The response sits in an output register; the next request is accepted
// while it waits. If rsp_chan is stalled when a further result is done,
// the block holds it and does not accept until the register frees.
// Reset (synchronous, active high) empties all buckets, returns every node
// to the pool and rewinds the read cursor; no clearing pass is needed.
`default_nettype none
module keyed_bucket_sorter #(
   parameter int KEY_BITS   = 8,
   parameter int VALUE_BITS = 32,
   parameter int POOL_DEPTH = 1024
) (
   input  wire logic clock,
   input  wire logic reset,
   kbs_req_if.sink   req_chan,
   kbs_rsp_if.source rsp_chan
);
   localparam int NODE_BITS = $clog2(POOL_DEPTH + 1);

   kbs_pkg::cmd_type  cmd;
   kbs_pkg::stat_type stat;
   logic              ready;

   assign req_chan.ready = ready;

   kbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .stat      (stat),
      .req_ready (ready),
      .cmd       (cmd)
   );

   kbs_datapath #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .POOL_DEPTH (POOL_DEPTH),
      .NODE_BITS  (NODE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_mode   (req_chan.mode),
      .req_key    (req_chan.key),
      .req_value  (req_chan.item_value),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_status (rsp_chan.status),
      .rsp_key    (rsp_chan.out_key),
      .rsp_value  (rsp_chan.out_value),
      .rsp_count  (rsp_chan.removed_count)
   );
endmodule
`default_nettype wire

>>> sim/keyed_bucket_sorter_test.sv
// Self-checking testbench of the keyed bucket sorter: directed table, then random traffic.
`default_nettype none
module keyed_bucket_sorter_test;

   localparam int POOL = 1024;
   localparam int KEYS = 256;
   localparam logic [kbs_pkg::MODE_BITS-1:0] MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 10000000;

   typedef struct packed {
      logic [kbs_pkg::STATUS_BITS-1:0] status;
      logic [7:0]                      out_key;
      logic [31:0]                     out_value;
      logic [10:0]                     removed_count;
   } answer_type;

   typedef struct packed {
      logic [kbs_pkg::MODE_BITS-1:0] mode;
      logic [7:0]                    key;
      logic [31:0]                   item_value;
      logic                          typed;
      answer_type                    answer;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   kbs_req_if #(.KEY_BITS(8), .VALUE_BITS(32)) req_chan ();
   kbs_rsp_if #(.KEY_BITS(8), .VALUE_BITS(32), .COUNT_BITS(11)) rsp_chan ();

   keyed_bucket_sorter #(.KEY_BITS(8), .VALUE_BITS(32), .POOL_DEPTH(POOL)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sorter state as seen by the predictor
   logic [31:0] node_val [POOL];
   int          node_next [POOL];
   int          head [KEYS];
   int          tail [KEYS];
   logic        occupied [KEYS];
   int          fresh_nodes;
   int          recycled_top;
   int          cursor_key;
   int          cursor_node;

   answer_type pending_answers [$];
   int      errors = 0;
   int      cycles = 0;
   int      n_insert = 0, n_full = 0, n_remove = 0, n_removed = 0, n_read = 0, n_end = 0;
   logic    sender_quiet = 1'b0;
   logic    receiver_quiet = 1'b0;

   function automatic answer_type sort_step(input logic [kbs_pkg::MODE_BITS-1:0] mode,
                                            input logic [7:0] key,
                                            input logic [31:0] val);
      answer_type a;
      int n, prev, cur, nxt, k, count;
      a = '0;
      if (mode == kbs_pkg::MODE_INSERT) begin
         n = -1;
         if (recycled_top < POOL) begin
            n = recycled_top;
            recycled_top = node_next[n];
         end else if (fresh_nodes < POOL) begin
            n = fresh_nodes;
            fresh_nodes++;
         end
         if (n < 0) begin
            a.status = kbs_pkg::ST_FULL;
            n_full++;
         end else begin
            node_val[n] = val;
            node_next[n] = POOL;
            if (occupied[key] && tail[key] < POOL) begin
               node_next[tail[key]] = n;
            end else begin
               head[key] = n;
               occupied[key] = 1'b1;
            end
            tail[key] = n;
         end
         n_insert++;
      end else if (mode == kbs_pkg::MODE_REMOVE) begin
         count = 0;
         cursor_key = 0;
         cursor_node = POOL;
         if (occupied[key]) begin
            prev = POOL;
            cur = head[key];
            while (cur < POOL) begin
               nxt = node_next[cur];
               if (node_val[cur] == val) begin
                  if (prev == POOL) head[key] = nxt;
                  else node_next[prev] = nxt;
                  node_next[cur] = recycled_top;
                  recycled_top = cur;
                  count++;
               end else begin
                  prev = cur;
               end
               cur = nxt;
            end
            if (prev == POOL) begin
               occupied[key] = 1'b0;
            end else begin
               node_next[prev] = POOL;
               tail[key] = prev;
            end
         end
         a.removed_count = 11'(count);
         n_remove++;
         n_removed += count;
      end else if (mode == kbs_pkg::MODE_READ) begin
         k = cursor_key;
         n = cursor_node;
         if (n >= POOL) begin
            while (k < KEYS && !occupied[k]) k++;
            if (k < KEYS) n = head[k];
         end
         if (k >= KEYS || n >= POOL) begin
            cursor_key = 0;
            cursor_node = POOL;
            a.status = kbs_pkg::ST_END;
            n_end++;
         end else begin
            a.out_key = 8'(k);
            a.out_value = node_val[n];
            nxt = node_next[n];
            if (nxt >= POOL) begin
               cursor_key = k + 1;
               cursor_node = POOL;
            end else begin
               cursor_key = k;
               cursor_node = nxt;
            end
         end
         n_read++;
      end
      return a;
   endfunction

   task automatic send_word(input row_type r);
      answer_type a;
      if (!sender_quiet && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.mode       <= r.mode;
      req_chan.key        <= r.key;
      req_chan.item_value <= r.item_value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      a = sort_step(r.mode, r.key, r.item_value);
      pending_answers.push_back(r.typed ? r.answer : a);
   endtask

   function automatic logic [7:0] pick_key();
      if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, 15) * 17);
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [31:0] pick_value();
      logic [31:0] common [8];
      common = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'h7};
      if ($urandom_range(0, 9) < 6) return common[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   function automatic row_type random_row(input int insert_pct, input int remove_pct);
      row_type r;
      int p;
      r = '0;
      p = $urandom_range(0, 99);
      if (p < insert_pct) r.mode = kbs_pkg::MODE_INSERT;
      else if (p < insert_pct + remove_pct) r.mode = kbs_pkg::MODE_REMOVE;
      else if (p < 97) r.mode = kbs_pkg::MODE_READ;
      else r.mode = MODE_UNUSED;
      r.key = pick_key();
      r.item_value = pick_value();
      return r;
   endfunction

   function automatic row_type row(input logic [kbs_pkg::MODE_BITS-1:0] m,
                                   input logic [7:0] k,
                                   input logic [31:0] v, input logic typed,
                                   input logic [kbs_pkg::STATUS_BITS-1:0] st,
                                   input logic [7:0] ok,
                                   input logic [31:0] ov, input logic [10:0] rc);
      row_type r;
      r.mode = m;
      r.key = k;
      r.item_value = v;
      r.typed = typed;
      r.answer = '{st, ok, ov, rc};
      return r;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected word st=%0d key=%0d val=%h cnt=%0d", $time,
                     rsp_chan.status, rsp_chan.out_key, rsp_chan.out_value,
                     rsp_chan.removed_count);
            errors++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_chan.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_chan.status);
               errors++;
            end
            if (rsp_chan.out_key !== want.out_key) begin
               $display("%0t: out_key expected %0d actual %0d", $time, want.out_key,
                        rsp_chan.out_key);
               errors++;
            end
            if (rsp_chan.out_value !== want.out_value) begin
               $display("%0t: out_value expected %h actual %h", $time, want.out_value,
                        rsp_chan.out_value);
               errors++;
            end
            if (rsp_chan.removed_count !== want.removed_count) begin
               $display("%0t: removed_count expected %0d actual %0d", $time,
                        want.removed_count, rsp_chan.removed_count);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d words outstanding", $time, pending_answers.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (!receiver_quiet && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   initial begin
      row_type table_rows [$];
      row_type r;
      req_chan.valid = 1'b0;
      req_chan.mode = kbs_pkg::MODE_INSERT;
      req_chan.key = '0;
      req_chan.item_value = '0;
      for (int i = 0; i < KEYS; i++) occupied[i] = 1'b0;
      fresh_nodes = 0;
      recycled_top = POOL;
      cursor_key = 0;
      cursor_node = POOL;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      table_rows = '{
         row(kbs_pkg::MODE_READ, 8'd0, 32'h0, 1, kbs_pkg::ST_END, 8'd0, 32'h0, 11'd0),
         row(kbs_pkg::MODE_REMOVE, 8'd255, 32'h0, 1, kbs_pkg::ST_OK, 8'd0, 32'h0, 11'd0),
         row(MODE_UNUSED, 8'd255, 32'hFFFF_FFFF, 1, kbs_pkg::ST_OK, 8'd0, 32'h0, 11'd0),
         row(kbs_pkg::MODE_INSERT, 8'd0, 32'h0, 1, kbs_pkg::ST_OK, 8'd0, 32'h0, 11'd0),
         row(kbs_pkg::MODE_INSERT, 8'd255, 32'hFFFF_FFFF, 1, kbs_pkg::ST_OK, 8'd0, 32'h0,
             11'd0),
         row(kbs_pkg::MODE_INSERT, 8'd255, 32'h5, 0, kbs_pkg::ST_OK, 8'd0, 32'h0, 11'd0),
         row(kbs_pkg::MODE_INSERT, 8'd255, 32'hFFFF_FFFF, 0, kbs_pkg::ST_OK, 8'd0, 32'h0,
             11'd0),
         row(kbs_pkg::MODE_READ, 8'd0, 32'h0, 1, kbs_pkg::ST_OK, 8'd0, 32'h0, 11'd0),
         row(kbs_pkg::MODE_READ, 8'd0, 32'h0, 1, kbs_pkg::ST_OK, 8'd255, 32'hFFFF_FFFF,
             11'd0),
         row(kbs_pkg::MODE_INSERT, 8'd255, 32'h7, 0, kbs_pkg::ST_OK, 8'd0, 32'h0, 11'd0),
         row(kbs_pkg::MODE_READ, 8'd0, 32'h0, 0, kbs_pkg::ST_OK, 8'd0, 32'h0, 11'd0),
         row(kbs_pkg::MODE_READ, 8'd0, 32'h0, 0, kbs_pkg::ST_OK, 8'd0, 32'h0, 11'd0),
         row(kbs_pkg::MODE_READ, 8'd0, 32'h0, 0, kbs_pkg::ST_OK, 8'd0, 32'h0, 11'd0),
         row(kbs_pkg::MODE_READ, 8'd0, 32'h0, 1, kbs_pkg::ST_END, 8'd0, 32'h0, 11'd0),
         row(kbs_pkg::MODE_READ, 8'd0, 32'h0, 0, kbs_pkg::ST_OK, 8'd0, 32'h0, 11'd0),
         row(kbs_pkg::MODE_REMOVE, 8'd255, 32'hFFFF_FFFF, 1, kbs_pkg::ST_OK, 8'd0, 32'h0,
             11'd2),
         row(kbs_pkg::MODE_READ, 8'd0, 32'h0, 0, kbs_pkg::ST_OK, 8'd0, 32'h0, 11'd0),
         row(kbs_pkg::MODE_REMOVE, 8'd0, 32'h0, 1, kbs_pkg::ST_OK, 8'd0, 32'h0, 11'd1),
         row(kbs_pkg::MODE_READ, 8'd0, 32'h0, 0, kbs_pkg::ST_OK, 8'd0, 32'h0, 11'd0),
         row(kbs_pkg::MODE_INSERT, 8'd0, 32'h9, 0, kbs_pkg::ST_OK, 8'd0, 32'h0, 11'd0),
         row(kbs_pkg::MODE_READ, 8'd0, 32'h0, 0, kbs_pkg::ST_OK, 8'd0, 32'h0, 11'd0),
         row(kbs_pkg::MODE_READ, 8'd0, 32'h0, 0, kbs_pkg::ST_OK, 8'd0, 32'h0, 11'd0),
         row(kbs_pkg::MODE_READ, 8'd0, 32'h0, 0, kbs_pkg::ST_OK, 8'd0, 32'h0, 11'd0)
      };
      foreach (table_rows[i]) send_word(table_rows[i]);

      for (int i = 0; i < 60; i++) begin
         if (i == 30) begin
            // hold until the block has answered everything
            req_chan.valid <= 1'b0;
            while (pending_answers.size() != 0) @(posedge clock);
         end
         send_word(random_row(50, 18));
      end

      // fill the pool until inserts are dropped
      while (n_full < 4) begin
         r = random_row(97, 0);
         send_word(r);
      end

      for (int i = 0; i < 20; i++) send_word(random_row(20, 45));

      // finish with no idling on either side
      sender_quiet = 1'b1;
      receiver_quiet = 1'b1;
      for (int i = 0; i < 40; i++) send_word(random_row(20, 45));
      req_chan.valid <= 1'b0;

      while (pending_answers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Covered %0d inserts (%0d dropped full), %0d removes (%0d entries deleted),",
               n_insert, n_full, n_remove, n_removed);
      $display("and %0d reads with %0d end-of-contents answers.", n_read, n_end);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
